>>> design/tkf_pkg.sv
// Shared types, constants and helper functions of the two-axis tilt Kalman filter.
package tkf_pkg;

	localparam int unsigned FIELD_W = 32;
	localparam int unsigned CFG_W   = 31;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_TIME_STEP   = 2'd0;
	localparam logic [1:0] REG_ANGLE_NOISE = 2'd1;
	localparam logic [1:0] REG_BIAS_NOISE  = 2'd2;
	localparam logic [1:0] REG_MEAS_NOISE  = 2'd3;

	// Register reset values.
	localparam logic [CFG_W-1:0] TIME_STEP_RST   = 31'd2684355;
	localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 31'd268435;
	localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 31'd1342177;
	localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 31'd8053064;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIFF,
		OP_M_D,
		OP_EST,
		OP_T1,
		OP_M_IN,
		OP_PCOV,
		OP_DIV,
		OP_M_K0Y,
		OP_UE,
		OP_UB,
		OP_U0,
		OP_U1,
		OP_U2,
		OP_U3,
		OP_STORE
	} op_t;

	localparam int unsigned PRED_LEN = 8;
	localparam int unsigned CORR_LEN = 7;

	// Predict phase: load axis state, integrate the rate, grow the covariance,
	// then launch the gain division.
	localparam op_t PRED_SEQ [PRED_LEN] = '{
		OP_LOAD, OP_DIFF, OP_M_D, OP_EST, OP_T1, OP_M_IN, OP_PCOV, OP_DIV
	};

	// Correct phase: apply the gains to the estimate, bias and covariance.
	localparam op_t CORR_SEQ [CORR_LEN] = '{
		OP_M_K0Y, OP_UE, OP_UB, OP_U0, OP_U1, OP_U2, OP_U3
	};

	typedef struct packed {
		op_t  op;
		logic ax;
		logic in_load;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

	// Saturate an exact sum to signed 32 bits.
	function automatic logic signed [31:0] sat36(input logic signed [35:0] x);
		logic signed [31:0] r;
		if (x > 36'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -36'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// Saturate a shifted product to signed 32 bits.
	function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

>>> design/tkf_div.sv
// Serial signed divider forming both Kalman gains against one shared divisor.
module tkf_div #(
	parameter int unsigned COV_FRAC_BITS = 28
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] divisor,
	input  logic signed [31:0] num0,
	input  logic signed [31:0] num1,
	output logic signed [31:0] gain0,
	output logic signed [31:0] gain1,
	output logic               done
);
	import tkf_pkg::*;

	localparam int unsigned DW = 32 + COV_FRAC_BITS;

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic        zero_q;
	logic [32:0] v_q;
	logic [33:0] rem0_q, rem1_q;
	logic [31:0] sh0_q, sh1_q;
	logic [31:0] q0_q, q1_q;
	logic        neg0_q, neg1_q;
	logic        over0_q, over1_q;
	logic        done_q;
	logic signed [31:0] gain0_q, gain1_q;

	logic [32:0] v_mag;
	logic [31:0] n0_mag, n1_mag;
	logic [DW-1:0] d0, d1;
	logic [33:0] t0, t1;
	logic        ge0, ge1;

	// Final gain from quotient magnitude, sign and overflow flags.
	function automatic logic signed [31:0] fin(input logic [31:0] q, input logic neg,
		input logic over, input logic zero);
		logic signed [31:0] r;
		if (zero) begin
			r = '0;
		end else if (over) begin
			r = neg ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			r = neg ? -$signed(q) : $signed(q);
		end
		return r;
	endfunction

	// Magnitudes and scaled dividends for the start cycle.
	always_comb begin
		v_mag  = divisor[32] ? 33'(-divisor) : 33'(divisor);
		n0_mag = num0[31] ? 32'(-num0) : 32'(num0);
		n1_mag = num1[31] ? 32'(-num1) : 32'(num1);
		d0     = {n0_mag, {COV_FRAC_BITS{1'b0}}};
		d1     = {n1_mag, {COV_FRAC_BITS{1'b0}}};
	end

	// One restoring step per cycle for each numerator.
	always_comb begin
		t0  = {rem0_q[32:0], sh0_q[31]};
		t1  = {rem1_q[32:0], sh1_q[31]};
		ge0 = t0 >= {1'b0, v_q};
		ge1 = t1 >= {1'b0, v_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= (divisor == '0) ? 6'd0 : 6'd32;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	// Datapath registers of the divider.
	always_ff @(posedge clk) begin
		if (start) begin
			zero_q  <= (divisor == '0);
			v_q     <= v_mag;
			rem0_q  <= 34'(d0[DW-1:32]);
			rem1_q  <= 34'(d1[DW-1:32]);
			sh0_q   <= d0[31:0];
			sh1_q   <= d1[31:0];
			q0_q    <= '0;
			q1_q    <= '0;
			neg0_q  <= num0[31] ^ divisor[32];
			neg1_q  <= num1[31] ^ divisor[32];
			over0_q <= 64'(d0) >= (64'(v_mag) << 31);
			over1_q <= 64'(d1) >= (64'(v_mag) << 31);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				gain0_q <= fin(q0_q, neg0_q, over0_q, zero_q);
				gain1_q <= fin(q1_q, neg1_q, over1_q, zero_q);
			end else begin
				rem0_q <= ge0 ? t0 - {1'b0, v_q} : t0;
				rem1_q <= ge1 ? t1 - {1'b0, v_q} : t1;
				sh0_q  <= {sh0_q[30:0], 1'b0};
				sh1_q  <= {sh1_q[30:0], 1'b0};
				q0_q   <= {q0_q[30:0], ge0};
				q1_q   <= {q1_q[30:0], ge1};
			end
		end
	end

	assign gain0 = gain0_q;
	assign gain1 = gain1_q;
	assign done  = done_q;

endmodule

>>> design/tkf_dp.sv
// Datapath: configuration, axis state, shared multiplier, adders and gain divider.
module tkf_dp #(
	parameter int unsigned COV_FRAC_BITS = 28
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tkf_pkg::cmd_t        cmd,
	output tkf_pkg::sts_t        sts,
	input  logic [127:0]         in_data,
	output logic [63:0]          out_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import tkf_pkg::*;

	logic [CFG_W-1:0] dt_q, qa_q, qb_q, r_q;

	logic signed [31:0] est_q [2];
	logic signed [31:0] bias_q [2];
	logic signed [31:0] cov_q [2][4];

	logic signed [31:0] in_q [4];
	logic signed [31:0] rate_q, meas_q;
	logic signed [31:0] e_q, b_q, p_q [4];
	logic signed [31:0] t1_q, tmp_q, y_q;
	logic signed [63:0] prod_q;
	logic [63:0]        out_q;

	logic signed [31:0] dt_s, qa_s, qb_s;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_d, rnd;
	logic signed [31:0] rs;
	logic signed [32:0] s_d;
	logic signed [31:0] k0, k1;
	logic               div_start;

	assign dt_s = $signed({1'b0, dt_q});
	assign qa_s = $signed({1'b0, qa_q});
	assign qb_s = $signed({1'b0, qb_q});

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= TIME_STEP_RST;
			qa_q <= ANGLE_NOISE_RST;
			qb_q <= BIAS_NOISE_RST;
			r_q  <= MEAS_NOISE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIME_STEP:   dt_q <= cfg_data[CFG_W-1:0];
				REG_ANGLE_NOISE: qa_q <= cfg_data[CFG_W-1:0];
				REG_BIAS_NOISE:  qb_q <= cfg_data[CFG_W-1:0];
				REG_MEAS_NOISE:  r_q  <= cfg_data[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = tmp_q;
		mul_b = dt_s;
		unique case (cmd.op)
			OP_M_D:   begin mul_a = tmp_q;  mul_b = dt_s;   end
			OP_EST:   begin mul_a = p_q[3]; mul_b = dt_s;   end
			OP_M_IN:  begin mul_a = dt_s;   mul_b = tmp_q;  end
			OP_M_K0Y: begin mul_a = k0;     mul_b = y_q;    end
			OP_UE:    begin mul_a = k1;     mul_b = y_q;    end
			OP_UB:    begin mul_a = k0;     mul_b = p_q[0]; end
			OP_U0:    begin mul_a = k0;     mul_b = p_q[1]; end
			OP_U1:    begin mul_a = k1;     mul_b = p_q[0]; end
			OP_U2:    begin mul_a = k1;     mul_b = p_q[1]; end
			default: ;
		endcase
		prod_d = mul_a * mul_b;
	end

	// Round half up, drop the fraction bits and saturate the last product.
	always_comb begin
		rnd = prod_q + (64'sd1 <<< (COV_FRAC_BITS - 1));
		rs  = sat64(rnd >>> COV_FRAC_BITS);
	end

	assign s_d       = 33'(p_q[0]) + 33'($signed({1'b0, r_q}));
	assign div_start = (cmd.op == OP_DIV);

	tkf_div #(
		.COV_FRAC_BITS(COV_FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (s_d),
		.num0    (p_q[0]),
		.num1    (p_q[2]),
		.gain0   (k0),
		.gain1   (k1),
		.done    (sts.div_done)
	);

	// Per-axis filter state, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 2; a++) begin
				est_q[a]  <= '0;
				bias_q[a] <= '0;
				for (int i = 0; i < 4; i++) begin
					cov_q[a][i] <= '0;
				end
			end
		end else if (cmd.op == OP_STORE) begin
			est_q[cmd.ax]  <= e_q;
			bias_q[cmd.ax] <= b_q;
			for (int i = 0; i < 4; i++) begin
				cov_q[cmd.ax][i] <= p_q[i];
			end
		end
	end

	// Working registers of the axis in progress.
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (cmd.in_load) begin
			for (int i = 0; i < 4; i++) begin
				in_q[i] <= in_data[32*i +: 32];
			end
		end
		if (cmd.out_load) begin
			out_q <= {e_q, est_q[0]};
		end
		unique case (cmd.op)
			OP_LOAD: begin
				rate_q <= cmd.ax ? in_q[2] : in_q[0];
				meas_q <= cmd.ax ? in_q[3] : in_q[1];
				e_q    <= est_q[cmd.ax];
				b_q    <= bias_q[cmd.ax];
				for (int i = 0; i < 4; i++) begin
					p_q[i] <= cov_q[cmd.ax][i];
				end
			end
			OP_DIFF: tmp_q <= sat36(36'(rate_q) - 36'(b_q));
			OP_EST:  e_q <= sat36(36'(e_q) + 36'(rs));
			OP_T1: begin
				t1_q  <= rs;
				tmp_q <= sat36(36'(rs) - 36'(p_q[1]) - 36'(p_q[2]));
			end
			OP_PCOV: begin
				p_q[0] <= sat36(36'(p_q[0]) + 36'(rs) + 36'(qa_s));
				p_q[1] <= sat36(36'(p_q[1]) - 36'(t1_q));
				p_q[2] <= sat36(36'(p_q[2]) - 36'(t1_q));
				p_q[3] <= sat36(36'(p_q[3]) + 36'(qb_s));
			end
			OP_DIV: y_q <= sat36(36'(meas_q) - 36'(e_q));
			OP_UE:  e_q <= sat36(36'(e_q) + 36'(rs));
			OP_UB:  b_q <= sat36(36'(b_q) + 36'(rs));
			OP_U0:  tmp_q <= sat36(36'(p_q[0]) - 36'(rs));
			OP_U1:  t1_q <= sat36(36'(p_q[1]) - 36'(rs));
			OP_U2:  p_q[2] <= sat36(36'(p_q[2]) - 36'(rs));
			OP_U3: begin
				p_q[3] <= sat36(36'(p_q[3]) - 36'(rs));
				p_q[0] <= tmp_q;
				p_q[1] <= t1_q;
			end
			default: ;
		endcase
	end

	assign out_data = out_q;

endmodule

>>> design/tkf_ctrl.sv
// Controller: sequences the datapath through both axes and runs the handshakes.
module tkf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output tkf_pkg::cmd_t cmd,
	input  tkf_pkg::sts_t sts
);
	import tkf_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PRED  = 5'b00010,
		S_DIVW  = 5'b00100,
		S_CORR  = 5'b01000,
		S_STORE = 5'b10000
	} state_t;

	state_t     state_q;
	logic [2:0] step_q;
	logic       ax_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Command decode.
	always_comb begin
		cmd          = '0;
		cmd.op       = OP_NONE;
		cmd.ax       = ax_q;
		cmd.in_load  = in_valid && in_ready;
		unique case (state_q)
			S_IDLE: ;
			S_PRED: cmd.op = PRED_SEQ[step_q];
			S_DIVW: ;
			S_CORR: cmd.op = CORR_SEQ[step_q];
			S_STORE: begin
				if (!ax_q || out_free) begin
					cmd.op       = OP_STORE;
					cmd.out_load = ax_q;
				end
			end
			default: ;
		endcase
	end

	// State sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			ax_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PRED;
						step_q  <= '0;
						ax_q    <= 1'b0;
					end
				end
				S_PRED: begin
					if (step_q == 3'(PRED_LEN - 1)) begin
						state_q <= S_DIVW;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_DIVW: begin
					if (sts.div_done) begin
						state_q <= S_CORR;
						step_q  <= '0;
					end
				end
				S_CORR: begin
					if (step_q == 3'(CORR_LEN - 1)) begin
						state_q <= S_STORE;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_STORE: begin
					if (!ax_q) begin
						ax_q    <= 1'b1;
						state_q <= S_PRED;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A new result appears only after the pitch axis has been stored.
	a_out_after_store: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_STORE && ax_q))
		else $error("result shown without a finished pitch axis");

	// The divider finishes only while the controller waits for it.
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == S_DIVW)
		else $error("divider finished outside its wait state");

	// An accepted item always starts with the roll axis.
	a_start_roll: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_PRED && !ax_q && step_q == '0))
		else $error("item did not start on the roll axis");

endmodule

>>> design/tilt_kalman_filter_two_axis.sv
// Top level of the two-axis tilt Kalman filter.
// Each item is one IMU sample; the block runs a two-state angle/bias Kalman
// filter for roll and then for pitch and returns both filtered angles as one
// item. Per axis it runs 16 datapath steps (8 predict, 7 correct, 1 store) on
// a single shared 32x32 multiplier and waits for the gain division, which
// produces one quotient bit per cycle for both gains at once. The result is
// offered in the cycle after the pitch store, and the next item can be accepted
// in that same cycle. One item is in work at a time; a finished result waits
// in an output register while the next item is accepted, and the pitch store
// of that next item stalls until the waiting result has been taken.
// Configuration writes are taken at any time and must be made only while no
// item is in work.
module tilt_kalman_filter_two_axis #(
	parameter int unsigned COV_FRAC_BITS = 28
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// roll_rate_in, roll_angle_meas, pitch_rate_in, pitch_angle_meas
	input  logic [127:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// roll_filtered, pitch_filtered
	output logic [63:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import tkf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tkf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tkf_dp #(
		.COV_FRAC_BITS(COV_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.out_data  (m_axis_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

>>> verif/tilt_kalman_filter_two_axis_checker.sv
// Checker of the two-axis tilt Kalman filter: predicts each result item and compares it.
module tilt_kalman_filter_two_axis_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [63:0]  m_axis_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           fail_count,
	output int           pending_count
);
	import tkf_pkg::*;

	typedef struct {
		longint est;
		longint bias;
		longint p [4];
	} axis_state_t;

	longint dt_q;
	longint q_angle;
	longint q_bias;
	longint r_meas;
	axis_state_t roll_st;
	axis_state_t pitch_st;
	logic [63:0] angle_queue [$];

	// Clamp to signed 32 bits.
	function automatic longint clamp32(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Fixed-point product with round half up, then clamp.
	function automatic longint qmul(input longint a, input longint b);
		longint p;
		p = a * b + (64'sd1 <<< 27);
		return clamp32(p >>> 28);
	endfunction

	function automatic longint qdiv(input longint num, input longint den);
		if (den == 0) return 0;
		return clamp32((num * (64'sd1 <<< 28)) / den);
	endfunction

	// One axis: predict, then correct with the measured angle.
	task automatic run_axis(inout axis_state_t a, input longint rate, input longint meas);
		longint d, t1, inner, t2, s, k0, k1, y, p00, p01;
		d = clamp32(rate - a.bias);
		a.est = clamp32(a.est + qmul(d, dt_q));
		t1 = qmul(a.p[3], dt_q);
		inner = clamp32(t1 - a.p[1] - a.p[2]);
		t2 = qmul(dt_q, inner);
		a.p[0] = clamp32(a.p[0] + t2 + q_angle);
		a.p[1] = clamp32(a.p[1] - t1);
		a.p[2] = clamp32(a.p[2] - t1);
		a.p[3] = clamp32(a.p[3] + q_bias);
		s = a.p[0] + r_meas;
		k0 = qdiv(a.p[0], s);
		k1 = qdiv(a.p[2], s);
		y = clamp32(meas - a.est);
		a.est = clamp32(a.est + qmul(k0, y));
		a.bias = clamp32(a.bias + qmul(k1, y));
		p00 = a.p[0];
		p01 = a.p[1];
		a.p[0] = clamp32(a.p[0] - qmul(k0, p00));
		a.p[1] = clamp32(a.p[1] - qmul(k0, p01));
		a.p[2] = clamp32(a.p[2] - qmul(k1, p00));
		a.p[3] = clamp32(a.p[3] - qmul(k1, p01));
	endtask

	assign pending_count = angle_queue.size();

	// Track configuration, predict on accepted inputs, compare accepted outputs.
	always @(posedge clk or negedge arst_n) begin
		longint rr, ra, pr, pa;
		logic [63:0] exp_item;
		if (!arst_n) begin
			dt_q = TIME_STEP_RST;
			q_angle = ANGLE_NOISE_RST;
			q_bias = BIAS_NOISE_RST;
			r_meas = MEAS_NOISE_RST;
			roll_st = '{0, 0, '{0, 0, 0, 0}};
			pitch_st = '{0, 0, '{0, 0, 0, 0}};
			angle_queue.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TIME_STEP: dt_q = cfg_data[30:0];
					REG_ANGLE_NOISE: q_angle = cfg_data[30:0];
					REG_BIAS_NOISE: q_bias = cfg_data[30:0];
					REG_MEAS_NOISE: r_meas = cfg_data[30:0];
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (angle_queue.size() == 0) begin
					$error("unexpected result item %h", m_axis_tdata);
					fail_count++;
				end else begin
					exp_item = angle_queue.pop_front();
					if (m_axis_tdata[31:0] !== exp_item[31:0]) begin
						$error("roll_filtered expected %h actual %h",
							exp_item[31:0], m_axis_tdata[31:0]);
						fail_count++;
					end
					if (m_axis_tdata[63:32] !== exp_item[63:32]) begin
						$error("pitch_filtered expected %h actual %h",
							exp_item[63:32], m_axis_tdata[63:32]);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				rr = longint'($signed(s_axis_tdata[31:0]));
				ra = longint'($signed(s_axis_tdata[63:32]));
				pr = longint'($signed(s_axis_tdata[95:64]));
				pa = longint'($signed(s_axis_tdata[127:96]));
				run_axis(roll_st, rr, ra);
				run_axis(pitch_st, pr, pa);
				exp_item = {pitch_st.est[31:0], roll_st.est[31:0]};
				angle_queue.push_back(exp_item);
			end
		end
	end
endmodule

>>> verif/tilt_kalman_filter_two_axis_tb.sv
// Testbench top of the two-axis tilt Kalman filter: stimulus, watchdog and verdict.
module tilt_kalman_filter_two_axis_tb;
	import tkf_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = REG_TIME_STEP;
	logic [31:0]  cfg_data = '0;
	int           fail_count;
	int           pending_count;
	int           idle_cycles = 0;
	bit           calm_phase = 1'b0;
	bit           hold_sink = 1'b0;

	tilt_kalman_filter_two_axis DUT (.*);

	tilt_kalman_filter_two_axis_checker u_checker (.*);

	always #5 clk = ~clk;

	// Receiver: random stall bursts, none in the calm phase, a long hold on request.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_axis_tready <= 1'b0;
				for (n = 0; n < 800; n++) @(posedge clk);
				hold_sink = 1'b0;
			end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// Watchdog on cycles without any accepted item.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_sample(input logic [31:0] rr, ra, pr, pa);
		s_axis_tdata <= {pa, pr, ra, rr};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (!calm_phase && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_field(input int mode);
		case (mode)
			0: return $urandom();
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			default: return $signed($urandom_range(0, 20'hfffff)) - 32'sh80000;
		endcase
	endfunction

	task automatic random_samples(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			send_sample($urandom_range(0, 9) == 0 ? rand_field($urandom_range(0, 2)) :
					rand_field(3),
				$urandom_range(0, 9) == 0 ? rand_field($urandom_range(0, 2)) : rand_field(3),
				$urandom_range(0, 9) == 0 ? rand_field($urandom_range(0, 2)) : rand_field(3),
				$urandom_range(0, 9) == 0 ? rand_field($urandom_range(0, 2)) : rand_field(3));
		end
	endtask

	initial begin
		int ph;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items: field extremes with reset settings.
		send_sample(32'h0, 32'h0, 32'h0, 32'h0);
		send_sample(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_sample(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_sample(32'hffff_ffff, 32'h0001_0000, 32'h0000_0001, 32'hffff_0000);
		send_sample(32'h0005_0000, 32'h000a_0000, 32'hfffb_0000, 32'hfff6_0000);
		drain();

		// Zero time step and zero noises; the innovation variance is then the angle covariance alone.
		write_reg(REG_TIME_STEP, 32'h0);
		write_reg(REG_ANGLE_NOISE, 32'h0);
		write_reg(REG_BIAS_NOISE, 32'h0);
		write_reg(REG_MEAS_NOISE, 32'h0);
		send_sample(32'h0001_0000, 32'h0002_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_sample(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 32'h8765_4321);
		drain();

		// Largest settings; the top bit of the data is dropped.
		write_reg(REG_TIME_STEP, 32'hffff_ffff);
		write_reg(REG_ANGLE_NOISE, 32'hffff_ffff);
		write_reg(REG_BIAS_NOISE, 32'hffff_ffff);
		write_reg(REG_MEAS_NOISE, 32'hffff_ffff);
		send_sample(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_sample(32'h0, 32'h7fff_ffff, 32'hffff_ffff, 32'h0);
		send_sample(32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h8000_0000);
		drain();

		// Long receiver hold while samples keep coming.
		hold_sink = 1'b1;
		random_samples(10);
		drain();

		// Random phases with random and reset-like settings.
		for (ph = 0; ph < 6; ph++) begin
			write_reg(REG_TIME_STEP, ph == 0 ? TIME_STEP_RST : $urandom_range(0, 32'h0400_0000));
			write_reg(REG_ANGLE_NOISE, ph == 0 ? ANGLE_NOISE_RST : $urandom());
			write_reg(REG_BIAS_NOISE, ph == 0 ? BIAS_NOISE_RST : $urandom_range(0, 32'h0100_0000));
			write_reg(REG_MEAS_NOISE, ph == 1 ? 32'h0 : $urandom());
			random_samples(300);
			drain();
		end

		// Final stretch without idling.
		calm_phase = 1'b1;
		random_samples(180);
		drain();

		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
